### rtl/rwl_pkg.sv
// Shared types and constants for the reader-writer lock manager.
// Depends on nothing; used by rwl_queue and reader_writer_lock_manager.
package rwl_pkg;

   // Default sizes
   localparam int DEF_READ_QUEUE_DEPTH  = 16;
   localparam int DEF_WRITE_QUEUE_DEPTH = 16;
   localparam int DEF_MAX_READERS       = 255;
   localparam int DEF_THREAD_ID_BITS    = 8;

   // Fixed widths of the channel fields
   localparam int OP_BITS     = 3;
   localparam int TID_BITS    = 8;
   localparam int OUT_BITS    = 3;
   localparam int HOLDER_BITS = 9;
   localparam int HOLDER_MAX  = 255;

   // Signed holder count: -1 write-locked, 0 free, n > 0 readers
   typedef logic signed [HOLDER_BITS-1:0] holder_type;

   typedef enum logic [OP_BITS-1:0] {
      OP_RD_LOCK     = 3'd0,
      OP_TRY_RD_LOCK = 3'd1,
      OP_WR_LOCK     = 3'd2,
      OP_TRY_WR_LOCK = 3'd3,
      OP_UNLOCK      = 3'd4
   } op_type;

   typedef enum logic [OUT_BITS-1:0] {
      OC_GRANTED    = 3'd0,
      OC_BUSY       = 3'd1,
      OC_QUEUED     = 3'd2,
      OC_WOKE_RD    = 3'd3,
      OC_WOKE_WR    = 3'd4,
      OC_RELEASED   = 3'd5,
      OC_NOT_LOCKED = 3'd6,
      OC_FULL       = 3'd7
   } outcome_type;

   // Control handed to a waiter queue
   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctl_type;

endpackage

### rtl/rwl_cell.sv
// One entry of a waiter queue: holds a thread id, takes its neighbour's
// entry on a pop and the new id when a push lands here. No dependencies.
module rwl_cell #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             shift,
   input  logic             push_here,
   input  logic [WIDTH-1:0] next_data,
   input  logic [WIDTH-1:0] push_data,
   output logic [WIDTH-1:0] data
);

   logic [WIDTH-1:0] data_ff;
   logic [WIDTH-1:0] data_in;

   // New id wins over the neighbour's entry
   assign data_in = push_here ? push_data : next_data;

   always_ff @(posedge clock) begin
      if (shift || push_here) begin
         data_ff <= data_in;
      end
   end

   assign data = data_ff;

endmodule

### rtl/rwl_queue.sv
// Waiter FIFO built as a chain of rwl_cell entries; the head sits in cell 0
// and a pop moves every entry one place towards it. Uses rwl_pkg, rwl_cell.
module rwl_queue #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rwl_pkg::queue_ctl_type ctl,
   input  logic [WIDTH-1:0]      push_data,
   output logic [WIDTH-1:0]      head_data,
   output logic [CNT_W-1:0]      fill,
   output logic                  full
);

   logic [CNT_W-1:0] fill_ff;
   logic [CNT_W-1:0] fill_in;
   logic [WIDTH-1:0] cell_data [DEPTH];

   // Chain of entries, each fed by the one behind it
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic             push_here;
      logic [WIDTH-1:0] next_data;

      // After a pop the free slot is one place nearer the head
      assign push_here = ctl.push &&
                         (ctl.pop ? (fill_ff == CNT_W'(i + 1)) : (fill_ff == CNT_W'(i)));

      if (i == DEPTH - 1) begin : g_tail
         assign next_data = cell_data[i];
      end else begin : g_body
         assign next_data = cell_data[i + 1];
      end

      rwl_cell #(
         .WIDTH(WIDTH)
      ) u_cell (
         .clock     (clock),
         .shift     (ctl.pop),
         .push_here (push_here),
         .next_data (next_data),
         .push_data (push_data),
         .data      (cell_data[i])
      );
   end

   // Occupancy
   always_comb begin
      fill_in = fill_ff;
      if (ctl.push && !ctl.pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (ctl.pop && !ctl.push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   assign head_data = cell_data[0];
   assign fill      = fill_ff;
   assign full      = (fill_ff == CNT_W'(DEPTH));

endmodule

### rtl/reader_writer_lock_manager.sv
// Reader-writer lock with writer preference: request decode, holder count,
// output register and the two waiter queues. Uses rwl_pkg and rwl_queue.
//
// Usage:
//   Request channel (req_*): an operation and the requesting thread id.
//   Response channel (rsp_*): one transfer per result, rsp_last on the final
//   result of a request. Lock, try and most unlock requests give one result;
//   an unlock that frees the lock gives "released" and then one result per
//   woken waiter (one writer, or readers up to the reader limit).
//   Configuration: csr_write_enable writes csr_write_data into the unlock
//   check bit, which reset sets to 1.
// Timing:
//   The first result is registered in the cycle after the request transfer.
//   Each woken waiter then gives one more result; the wake sequencer pops
//   one queue cell a cycle while the output register is free.
//   A single-result request can be followed by the next one in the next
//   cycle, giving one request per cycle when the receiver does not stall.
//   While rsp_stall is high the result is held and req_stall rises until the
//   output register is free. Reset empties both queues, frees the lock and
//   discards any pending result; no clearing pass is needed.
module reader_writer_lock_manager #(
   parameter int READ_QUEUE_DEPTH  = rwl_pkg::DEF_READ_QUEUE_DEPTH,
   parameter int WRITE_QUEUE_DEPTH = rwl_pkg::DEF_WRITE_QUEUE_DEPTH,
   parameter int MAX_READERS       = rwl_pkg::DEF_MAX_READERS,
   parameter int THREAD_ID_BITS    = rwl_pkg::DEF_THREAD_ID_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [rwl_pkg::OP_BITS-1:0]  req_operation,
   input  logic [rwl_pkg::TID_BITS-1:0] req_thread_id,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [rwl_pkg::TID_BITS-1:0] rsp_target_thread,
   output logic [rwl_pkg::OUT_BITS-1:0] rsp_outcome,
   output logic                         rsp_last,
   input  logic                         csr_write_enable,
   input  logic                         csr_write_data
);

   localparam int TID_W = (THREAD_ID_BITS < rwl_pkg::TID_BITS) ?
                          THREAD_ID_BITS : rwl_pkg::TID_BITS;
   localparam int LIMIT = (MAX_READERS < rwl_pkg::HOLDER_MAX) ?
                          MAX_READERS : rwl_pkg::HOLDER_MAX;
   localparam int RQ_CNT_W = $clog2(READ_QUEUE_DEPTH + 1);
   localparam int WQ_CNT_W = $clog2(WRITE_QUEUE_DEPTH + 1);
   localparam rwl_pkg::holder_type HOLD_LIMIT      = rwl_pkg::HOLDER_BITS'(LIMIT);
   localparam rwl_pkg::holder_type HOLD_LIMIT_LESS = rwl_pkg::HOLDER_BITS'(LIMIT - 1);
   localparam rwl_pkg::holder_type HOLD_ONE        = rwl_pkg::HOLDER_BITS'(1);
   localparam rwl_pkg::holder_type HOLD_WRITER     = '1;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_WAKE_WR = 3'b010,
      ST_WAKE_RD = 3'b100
   } state_type;

   state_type                    state_ff, state_in;
   rwl_pkg::holder_type          holder_ff, holder_in;
   logic                         check_unlock_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [rwl_pkg::TID_BITS-1:0] rsp_tid_ff, rsp_tid_in;
   rwl_pkg::outcome_type         rsp_outcome_ff, rsp_outcome_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic                         emit;

   logic                         out_free;
   logic                         accept;
   logic                         blocked_rd;
   logic [TID_W-1:0]             req_tid;
   logic [rwl_pkg::TID_BITS-1:0] req_tid_ext;

   rwl_pkg::queue_ctl_type       rq_ctl, wq_ctl;
   logic [TID_W-1:0]             rq_head, wq_head;
   logic [RQ_CNT_W-1:0]          rq_fill;
   logic [WQ_CNT_W-1:0]          wq_fill;
   logic                         rq_full, wq_full;
   logic                         rq_busy, wq_busy;

   // Handshake
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == ST_IDLE) && out_free);
   assign accept     = req_valid && !req_stall;

   assign req_tid     = req_thread_id[TID_W-1:0];
   assign req_tid_ext = rwl_pkg::TID_BITS'(req_tid);
   assign rq_busy     = (rq_fill != '0);
   assign wq_busy     = (wq_fill != '0);
   assign blocked_rd  = (holder_ff < 0) || wq_busy;

   // Waiter queues
   rwl_queue #(
      .DEPTH(READ_QUEUE_DEPTH),
      .WIDTH(TID_W)
   ) u_reader_queue (
      .clock     (clock),
      .reset     (reset),
      .ctl       (rq_ctl),
      .push_data (req_tid),
      .head_data (rq_head),
      .fill      (rq_fill),
      .full      (rq_full)
   );

   rwl_queue #(
      .DEPTH(WRITE_QUEUE_DEPTH),
      .WIDTH(TID_W)
   ) u_writer_queue (
      .clock     (clock),
      .reset     (reset),
      .ctl       (wq_ctl),
      .push_data (req_tid),
      .head_data (wq_head),
      .fill      (wq_fill),
      .full      (wq_full)
   );

   // Request decode and wake sequencer
   always_comb begin
      state_in       = state_ff;
      holder_in      = holder_ff;
      emit           = 1'b0;
      rsp_tid_in     = req_tid_ext;
      rsp_outcome_in = rwl_pkg::OC_GRANTED;
      rsp_last_in    = 1'b1;
      rq_ctl         = '0;
      wq_ctl         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (rwl_pkg::op_type'(req_operation))
                  rwl_pkg::OP_RD_LOCK, rwl_pkg::OP_TRY_RD_LOCK: begin
                     emit = 1'b1;
                     priority if (blocked_rd) begin
                        if (req_operation == rwl_pkg::OP_TRY_RD_LOCK) begin
                           rsp_outcome_in = rwl_pkg::OC_BUSY;
                        end else if (rq_full) begin
                           rsp_outcome_in = rwl_pkg::OC_FULL;
                        end else begin
                           rq_ctl.push    = 1'b1;
                           rsp_outcome_in = rwl_pkg::OC_QUEUED;
                        end
                     end else if (holder_ff >= HOLD_LIMIT) begin
                        rsp_outcome_in = rwl_pkg::OC_FULL;
                     end else begin
                        holder_in      = holder_ff + HOLD_ONE;
                        rsp_outcome_in = rwl_pkg::OC_GRANTED;
                     end
                  end
                  rwl_pkg::OP_WR_LOCK, rwl_pkg::OP_TRY_WR_LOCK: begin
                     emit = 1'b1;
                     if (holder_ff != '0) begin
                        if (req_operation == rwl_pkg::OP_TRY_WR_LOCK) begin
                           rsp_outcome_in = rwl_pkg::OC_BUSY;
                        end else if (wq_full) begin
                           rsp_outcome_in = rwl_pkg::OC_FULL;
                        end else begin
                           wq_ctl.push    = 1'b1;
                           rsp_outcome_in = rwl_pkg::OC_QUEUED;
                        end
                     end else begin
                        holder_in      = HOLD_WRITER;
                        rsp_outcome_in = rwl_pkg::OC_GRANTED;
                     end
                  end
                  rwl_pkg::OP_UNLOCK: begin
                     emit           = 1'b1;
                     rsp_outcome_in = rwl_pkg::OC_RELEASED;
                     priority if (holder_ff == HOLD_ONE || holder_ff == HOLD_WRITER) begin
                        // last holder leaves: a writer wins over readers
                        holder_in   = '0;
                        rsp_last_in = !(wq_busy || rq_busy);
                        if (wq_busy) begin
                           state_in = ST_WAKE_WR;
                        end else if (rq_busy) begin
                           state_in = ST_WAKE_RD;
                        end
                     end else if (holder_ff == '0) begin
                        if (check_unlock_ff) begin
                           rsp_outcome_in = rwl_pkg::OC_NOT_LOCKED;
                        end else begin
                           holder_in = HOLD_WRITER;
                        end
                     end else begin
                        holder_in = holder_ff - HOLD_ONE;
                     end
                  end
                  default: begin
                     // unknown operation: no result
                  end
               endcase
            end
         end
         ST_WAKE_WR: begin
            if (out_free) begin
               emit           = 1'b1;
               wq_ctl.pop     = 1'b1;
               holder_in      = HOLD_WRITER;
               rsp_tid_in     = rwl_pkg::TID_BITS'(wq_head);
               rsp_outcome_in = rwl_pkg::OC_WOKE_WR;
               rsp_last_in    = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_WAKE_RD: begin
            if (out_free) begin
               // one reader per cycle while the output register is free, until the queue or the limit runs out
               emit           = 1'b1;
               rq_ctl.pop     = 1'b1;
               holder_in      = holder_ff + HOLD_ONE;
               rsp_tid_in     = rwl_pkg::TID_BITS'(rq_head);
               rsp_outcome_in = rwl_pkg::OC_WOKE_RD;
               rsp_last_in    = (rq_fill == RQ_CNT_W'(1)) || (holder_ff >= HOLD_LIMIT_LESS);
               if (rsp_last_in) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register valid
   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         holder_ff       <= '0;
         check_unlock_ff <= 1'b1;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         holder_ff    <= holder_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            check_unlock_ff <= csr_write_data;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_tid_ff     <= rsp_tid_in;
         rsp_outcome_ff <= rsp_outcome_in;
         rsp_last_ff    <= rsp_last_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_target_thread = rsp_tid_ff;
   assign rsp_outcome       = rsp_outcome_ff;
   assign rsp_last          = rsp_last_ff;

endmodule
